/* hdl/sbph_pkg.sv */
// sbph_pkg: shared types, constants and register codes of the spectrum bar peak hold block
// no dependencies
`default_nettype none
package sbph_pkg;

  localparam int unsigned BANDS_DEF       = 32;
  localparam int unsigned SAMPLE_BITS_DEF = 16;

  localparam int unsigned IN_W    = 16;
  localparam int unsigned HGT_W   = 13;
  localparam int unsigned HOLD_W  = 6;
  localparam int unsigned IDX_W   = 5;
  localparam int unsigned CADDR_W = 3;
  localparam int unsigned CDATA_W = 16;

  localparam logic [HGT_W-1:0] Q8_ONE = 13'd256;

  typedef enum logic [CADDR_W-1:0] {
    REG_SCALE_TARGET  = 3'd0,
    REG_MAX_HEIGHT    = 3'd1,
    REG_FALL_THRESH   = 3'd2,
    REG_FALL_STEP     = 3'd3,
    REG_HOLD_FRAMES   = 3'd4,
    REG_PEAK_DECAY    = 3'd5,
    REG_PEAK_RESET    = 3'd6,
    REG_UNUSED        = 3'd7
  } reg_idx_e;

  // per band display state carried along the cell row
  typedef struct packed {
    logic [HGT_W-1:0]  bar;
    logic [HGT_W-1:0]  marker;
    logic [HOLD_W-1:0] hold;
  } band_t;

endpackage
`default_nettype wire

/* hdl/sbph_if.sv */
// sbph channel interfaces: band input, result output and register write
// depends on sbph_pkg
`default_nettype none
interface sbph_in_if
  import sbph_pkg::*;
();
  logic            valid;
  logic            ready;
  logic [IN_W-1:0] band_value;
  modport source (output valid, output band_value, input ready);
  modport sink   (input valid, input band_value, output ready);
endinterface

interface sbph_out_if
  import sbph_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] band_index;
  logic [HGT_W-1:0] bar_height;
  logic [HGT_W-1:0] peak_level;
  logic             last_band;
  modport source (output valid, output band_index, output bar_height, output peak_level,
                  output last_band, input ready);
  modport sink   (input valid, input band_index, input bar_height, input peak_level,
                  input last_band, output ready);
endinterface

interface sbph_cfg_if
  import sbph_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [CADDR_W-1:0] index;
  logic [CDATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* hdl/sbph_cell.sv */
// sbph_cell: one band slot of the cell row, holds a magnitude and display state
// depends on sbph_pkg
`default_nettype none
module sbph_cell
  import sbph_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   load_i,
  input  wire logic                   rot_i,
  input  wire logic [SAMPLE_BITS-1:0] value_i,
  input  wire band_t                  state_i,
  output      logic [SAMPLE_BITS-1:0] value_o,
  output      band_t                  state_o
);

  logic [SAMPLE_BITS-1:0] value_q;
  band_t                  state_q;

  always_ff @(posedge clk_i) begin
    if (load_i || rot_i) begin
      value_q <= value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (rot_i) begin
      state_q <= state_i;
    end
  end

  assign value_o = value_q;
  assign state_o = state_q;

endmodule
`default_nettype wire

/* hdl/sbph_div.sv */
// sbph_div: restoring radix-2 divider, one quotient bit per cycle
// depends on sbph_pkg
`default_nettype none
module sbph_div
  import sbph_pkg::*;
#(
  parameter int unsigned NUM_W = 29,
  parameter int unsigned DEN_W = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output      logic             busy_o,
  output      logic [NUM_W-1:0] quot_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [NUM_W-1:0] num_q, num_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;

  assign trial = {rem_q, num_q[NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};

  always_comb begin
    cnt_d = cnt_q;
    num_d = num_q;
    rem_d = rem_q;
    if (start_i) begin
      cnt_d = CNT_W'(NUM_W);
      num_d = num_i;
      rem_d = '0;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      if (trial >= {1'b0, den_q}) begin
        rem_d = diff[DEN_W-1:0];
        num_d = {num_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_d = trial[DEN_W-1:0];
        num_d = {num_q[NUM_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign busy_o = (cnt_q != '0);
  assign quot_o = num_q;

endmodule
`default_nettype wire

/* hdl/spectrum_bar_peak_hold.sv */
// spectrum_bar_peak_hold: top level, cell row, frame peak, sequencer and band update
// depends on sbph_pkg, sbph_if, sbph_cell, sbph_div
//
// Usage: band magnitudes arrive one request at a time on in_ch, BANDS per frame.
// Each value shifts into the tail of a row of cells; while a frame is loading
// in_ch is ready every cycle. The request carrying the last band closes the frame:
// the frame counter and the running peak are updated, then the row rotates once
// per band through one shared multiply and divide unit. Band 0 sits at the head,
// its magnitude times scale_target is registered (ST_MUL), the divider is started
// (ST_START) and divides by the frame peak (ST_DIV) until it is done, and the bar,
// marker and hold count are updated and written back at the tail (ST_UPD).
// Results go out on out_ch in band order, with last_band on the final one.
// A result waits in the output register; if out_ch stalls, the update of the
// next band waits, and in_ch is not ready again until the last band is issued.
// Registers are written on cfg_ch, always ready; the user must write them only
// while the block is idle, which the block itself does not enforce.
// Reset clears bars, markers, hold counts, frame peak and counters and loads
// the register defaults; no clearing pass is needed.
`default_nettype none
module spectrum_bar_peak_hold
  import sbph_pkg::*;
#(
  parameter int unsigned BANDS       = BANDS_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sbph_in_if.sink   in_ch,
  sbph_out_if.source out_ch,
  sbph_cfg_if.sink  cfg_ch
);

  localparam int unsigned IW    = $clog2(BANDS);
  localparam int unsigned NUM_W = SAMPLE_BITS + HGT_W;

  typedef enum logic [4:0] {
    ST_LOAD  = 5'b00001,
    ST_MUL   = 5'b00010,
    ST_START = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_UPD   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // registers
  logic [HGT_W-1:0]  scale_q, maxh_q;
  logic [9:0]        thr_q, step_q;
  logic [HOLD_W-1:0] holdf_q;
  logic [7:0]        decay_q, prf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= 13'd5120;
      maxh_q  <= 13'd7680;
      thr_q   <= 10'd154;
      step_q  <= 10'd179;
      holdf_q <= 6'd30;
      decay_q <= 8'd102;
      prf_q   <= 8'd25;
    end else if (cfg_ch.valid) begin
      unique case (reg_idx_e'(cfg_ch.index))
        REG_SCALE_TARGET: scale_q <= cfg_ch.data[HGT_W-1:0];
        REG_MAX_HEIGHT:   maxh_q  <= cfg_ch.data[HGT_W-1:0];
        REG_FALL_THRESH:  thr_q   <= cfg_ch.data[9:0];
        REG_FALL_STEP:    step_q  <= cfg_ch.data[9:0];
        REG_HOLD_FRAMES:  holdf_q <= cfg_ch.data[HOLD_W-1:0];
        REG_PEAK_DECAY:   decay_q <= cfg_ch.data[7:0];
        REG_PEAK_RESET:   prf_q   <= cfg_ch.data[7:0];
        default: ;
      endcase
    end
  end
  assign cfg_ch.ready = 1'b1;

  // cell row
  logic [SAMPLE_BITS-1:0] val_w [BANDS+1];
  band_t                  st_w  [BANDS+1];
  logic                   load_en, rot_en;
  logic [SAMPLE_BITS-1:0] in_val;
  band_t                  upd_st;

  assign in_val   = SAMPLE_BITS'(in_ch.band_value);
  assign val_w[BANDS] = load_en ? in_val : val_w[0];
  assign st_w[BANDS]  = upd_st;

  for (genvar k = 0; k < BANDS; k++) begin : g_cell
    sbph_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .load_i  (load_en),
      .rot_i   (rot_en),
      .value_i (val_w[k+1]),
      .state_i (st_w[k+1]),
      .value_o (val_w[k]),
      .state_o (st_w[k])
    );
  end

  // load side, frame peak
  logic [IW-1:0]          ld_cnt_q, idx_q;
  logic [SAMPLE_BITS-1:0] fmax_q, peak_q, fmax_now, held;
  logic [7:0]             fcnt_q;
  logic [8:0]             fnext;
  logic                   in_fire, last_ld, clr;

  assign in_ch.ready = (state_q == ST_LOAD);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign load_en     = in_fire;
  assign last_ld     = (ld_cnt_q == IW'(BANDS - 1));
  assign fmax_now    = (ld_cnt_q == '0 || in_val > fmax_q) ? in_val : fmax_q;
  assign fnext       = {1'b0, fcnt_q} + 9'd1;
  assign clr         = fnext > {1'b0, prf_q};
  assign held        = clr ? '0 : peak_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ld_cnt_q <= '0;
      peak_q   <= '0;
      fcnt_q   <= '0;
    end else if (in_fire) begin
      if (last_ld) begin
        ld_cnt_q <= '0;
        fcnt_q   <= clr ? 8'd0 : fnext[7:0];
        peak_q   <= (fmax_now > held) ? fmax_now : held;
      end else begin
        ld_cnt_q <= ld_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      fmax_q <= fmax_now;
    end
  end

  // multiply and divide
  logic [NUM_W-1:0] prod_q, quot;
  logic             div_busy;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_MUL) begin
      prod_q <= NUM_W'(val_w[0]) * NUM_W'(scale_q);
    end
  end

  sbph_div #(.NUM_W(NUM_W), .DEN_W(SAMPLE_BITS)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == ST_START),
    .num_i   (prod_q),
    .den_i   (peak_q),
    .busy_o  (div_busy),
    .quot_o  (quot)
  );

  // band update
  logic [HGT_W-1:0]  y_sc, y, old, mk;
  logic [HOLD_W-1:0] hd;
  logic              out_free;

  always_comb begin
    if (peak_q == '0) begin
      y_sc = '0;
    end else if (quot > NUM_W'(maxh_q)) begin
      y_sc = maxh_q;
    end else begin
      y_sc = quot[HGT_W-1:0];
    end
    old = st_w[0].bar;
    y   = y_sc;
    if (old > y_sc && (old - y_sc) > HGT_W'(thr_q)) begin
      y = (old > HGT_W'(step_q)) ? (old - HGT_W'(step_q)) : '0;
    end
    mk = st_w[0].marker;
    hd = st_w[0].hold;
    if (y > mk) begin
      mk = y;
      hd = holdf_q;
    end
    if (hd != '0) begin
      hd = hd - 1'b1;
    end
    if (mk > Q8_ONE && hd == '0) begin
      mk = mk - HGT_W'(decay_q);
    end
    upd_st = '{bar: y, marker: mk, hold: hd};
  end

  assign out_free = !out_ch.valid || out_ch.ready;
  assign rot_en   = (state_q == ST_UPD) && out_free;

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD:  if (in_fire && last_ld) state_d = ST_MUL;
      ST_MUL:   state_d = ST_START;
      ST_START: state_d = ST_DIV;
      ST_DIV:   if (!div_busy) state_d = ST_UPD;
      ST_UPD:   if (out_free) state_d = (idx_q == IW'(BANDS - 1)) ? ST_LOAD : ST_MUL;
      default:  state_d = ST_LOAD;
    endcase
  end

  logic             ovalid_q;
  logic [IDX_W-1:0] oidx_q;
  logic [HGT_W-1:0] obar_q, opk_q;
  logic             olast_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_LOAD;
      idx_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (rot_en) begin
        ovalid_q <= 1'b1;
        idx_q    <= (idx_q == IW'(BANDS - 1)) ? '0 : idx_q + 1'b1;
      end else if (out_ch.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rot_en) begin
      oidx_q  <= IDX_W'(idx_q);
      obar_q  <= y;
      opk_q   <= mk;
      olast_q <= (idx_q == IW'(BANDS - 1));
    end
  end

  assign out_ch.valid      = ovalid_q;
  assign out_ch.band_index = oidx_q;
  assign out_ch.bar_height = obar_q;
  assign out_ch.peak_level = opk_q;
  assign out_ch.last_band  = olast_q;

endmodule
`default_nettype wire

/* verif/sbph_tb_if.sv */
// note: the channel interfaces come from hdl/sbph_if.sv
// this file only carries shared testbench constants
// depends on sbph_pkg
`timescale 1ns / 100ps
package sbph_tb_pkg;
  import sbph_pkg::*;
  localparam int unsigned TB_BANDS = BANDS_DEF;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
endpackage

/* verif/spectrum_bar_peak_hold_tb.sv */
// spectrum_bar_peak_hold_tb: drives frames of band magnitudes and register writes,
// predicts bars and peak markers per band and checks every result in order
// depends on sbph_pkg, sbph_if, sbph_tb_if, spectrum_bar_peak_hold
`timescale 1ns / 100ps
module spectrum_bar_peak_hold_tb;
  import sbph_pkg::*;
  import sbph_tb_pkg::*;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [HGT_W-1:0] bar;
    logic [HGT_W-1:0] mark;
    logic             last;
  } band_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  sbph_in_if  in_ch ();
  sbph_out_if out_ch ();
  sbph_cfg_if cfg_ch ();

  spectrum_bar_peak_hold uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // predictor state
  logic [12:0] p_scale, p_maxh;
  logic [9:0]  p_thr, p_step;
  logic [5:0]  p_holdf;
  logic [7:0]  p_decay, p_rstf;
  logic [15:0] frame_vals [TB_BANDS];
  logic [15:0] run_peak;
  logic [7:0]  frame_cnt;
  int          loaded;
  logic [12:0] bar_st [TB_BANDS];
  logic [12:0] mark_st [TB_BANDS];
  logic [5:0]  hold_st [TB_BANDS];

  band_res_t expected_bands [$];
  bit failed = 0;
  int send_idle = 0, recv_idle = 0;
  int quiet_cycles = 0;

  initial begin
    in_ch.valid = 1'b0; in_ch.band_value = '0;
    cfg_ch.valid = 1'b0; cfg_ch.index = REG_SCALE_TARGET; cfg_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  task automatic predict_reset();
    p_scale = 13'd5120; p_maxh = 13'd7680; p_thr = 10'd154; p_step = 10'd179;
    p_holdf = 6'd30; p_decay = 8'd102; p_rstf = 8'd25;
    run_peak = '0; frame_cnt = '0; loaded = 0;
    for (int i = 0; i < TB_BANDS; i++) begin
      bar_st[i] = '0; mark_st[i] = '0; hold_st[i] = '0; frame_vals[i] = '0;
    end
  endtask

  task automatic predict_frame(input logic [15:0] v);
    logic [8:0]  nxt;
    logic [31:0] y;
    logic [12:0] b, old;
    frame_vals[loaded] = v;
    if (loaded + 1 < TB_BANDS) begin
      loaded++;
      return;
    end
    loaded = 0;
    nxt = {1'b0, frame_cnt} + 9'd1;
    if (nxt > {1'b0, p_rstf}) begin
      frame_cnt = '0; run_peak = '0;
    end else begin
      frame_cnt = nxt[7:0];
    end
    for (int i = 0; i < TB_BANDS; i++)
      if (frame_vals[i] > run_peak) run_peak = frame_vals[i];
    for (int i = 0; i < TB_BANDS; i++) begin
      if (run_peak == 0) y = 0;
      else y = (frame_vals[i] * 32'(p_scale)) / run_peak;
      if (y > p_maxh) y = p_maxh;
      b = y[12:0];
      old = bar_st[i];
      if (old > b && (old - b) > p_thr) b = (old > p_step) ? old - p_step : 13'd0;
      bar_st[i] = b;
      if (b > mark_st[i]) begin
        mark_st[i] = b; hold_st[i] = p_holdf;
      end
      if (hold_st[i] > 0) hold_st[i]--;
      if (mark_st[i] > Q8_ONE && hold_st[i] == 0) mark_st[i] = mark_st[i] - 13'(p_decay);
      expected_bands.push_back('{idx: IDX_W'(i), bar: b, mark: mark_st[i],
                                 last: (i == TB_BANDS - 1)});
    end
  endtask

  task automatic send_band(input logic [15:0] v);
    while (send_idle > 0 && $urandom_range(99, 0) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.band_value <= v;
    do @(posedge clk_i); while (!in_ch.ready);
    predict_frame(v);
  endtask

  task automatic write_reg(input reg_idx_e r, input logic [15:0] d);
    while (expected_bands.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    cfg_ch.valid <= 1'b1; cfg_ch.index <= r; cfg_ch.data <= d;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (r)
      REG_SCALE_TARGET: p_scale = d[12:0];
      REG_MAX_HEIGHT:   p_maxh = d[12:0];
      REG_FALL_THRESH:  p_thr = d[9:0];
      REG_FALL_STEP:    p_step = d[9:0];
      REG_HOLD_FRAMES:  p_holdf = d[5:0];
      REG_PEAK_DECAY:   p_decay = d[7:0];
      REG_PEAK_RESET:   p_rstf = d[7:0];
      default: ;
    endcase
  endtask

  // result checker and receiver stall
  always @(posedge clk_i) begin
    band_res_t e;
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_bands.size() == 0) begin
          $error("unexpected result band %0d", out_ch.band_index);
          failed = 1;
        end else begin
          e = expected_bands.pop_front();
          if (out_ch.band_index !== e.idx) begin
            $error("band_index exp %0d got %0d", e.idx, out_ch.band_index); failed = 1;
          end
          if (out_ch.bar_height !== e.bar) begin
            $error("bar_height exp %0d got %0d", e.bar, out_ch.bar_height); failed = 1;
          end
          if (out_ch.peak_level !== e.mark) begin
            $error("peak_level exp %0d got %0d", e.mark, out_ch.peak_level); failed = 1;
          end
          if (out_ch.last_band !== e.last) begin
            $error("last_band exp %0d got %0d", e.last, out_ch.last_band); failed = 1;
          end
        end
      end
      out_ch.ready <= ($urandom_range(99, 0) >= recv_idle);
    end
  end

  // watchdog on accepted requests
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WATCHDOG_LIMIT) begin
      $display("spectrum_bar_peak_hold: mismatch");
      $finish;
    end
  end

  task automatic send_frame(input int kind);
    logic [15:0] v;
    for (int i = 0; i < TB_BANDS; i++) begin
      case (kind)
        0: v = 16'd0;
        1: v = 16'hFFFF;
        2: v = (i == 5) ? 16'hFFFF : 16'd1;
        3: v = 16'($urandom_range(255, 0));
        default: v = 16'($urandom());
      endcase
      send_band(v);
    end
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic test_directed();
    send_frame(0);   // zero peak: all bars zero
    send_frame(1);
  endtask

  task automatic test_config_extremes();
    write_reg(REG_SCALE_TARGET, 16'hFFFF);  // masked to width
    write_reg(REG_MAX_HEIGHT, 16'd1000);    // falloff bar stays above ceiling
    write_reg(REG_FALL_THRESH, 16'd0);
    write_reg(REG_FALL_STEP, 16'd0);
    write_reg(REG_HOLD_FRAMES, 16'd0);
    write_reg(REG_PEAK_DECAY, 16'd255);
    write_reg(REG_PEAK_RESET, 16'd0);   // peak clears every frame
    write_reg(REG_UNUSED, 16'hFFFF);    // ignored index
    send_frame(3);
    write_reg(REG_MAX_HEIGHT, 16'd7680);
    write_reg(REG_FALL_STEP, 16'd1023);
    write_reg(REG_HOLD_FRAMES, 16'd63);
  endtask

  task automatic test_random_frames(input int n);
    for (int f = 0; f < n; f++) send_frame($urandom_range(4, 0));
  endtask

  initial begin
    predict_reset();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle = 12; recv_idle = 61;
    test_directed();
    test_config_extremes();
    send_idle = 61; recv_idle = 12;
    write_reg(REG_PEAK_RESET, 16'd3);
    test_random_frames(1);
    send_idle = 0; recv_idle = 0;
    test_random_frames(1);
    while (expected_bands.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (!failed) $display("spectrum_bar_peak_hold: match");
    else $display("spectrum_bar_peak_hold: mismatch");
    $finish;
  end
endmodule
